>>> design/ngg_pkg.sv
// Shared types, constants and helpers for the non-uniform grid greeks stencil.
// Used by ngg_div and nonuniform_grid_greeks_stencil; depends on nothing.
package ngg_pkg;

	localparam int MAX_SPOT     = 64;
	localparam int MAX_VARIANCE = 64;
	localparam int FRAC_BITS    = 16;

	localparam int SPOT_W  = $clog2(MAX_SPOT);
	localparam int VAR_W   = $clog2(MAX_VARIANCE);
	localparam int NODE_W  = SPOT_W + VAR_W;
	localparam int DATA_W  = 32;
	localparam int PTS_W   = 7;
	localparam int TS_W    = 31;
	localparam int OP_W    = 36;
	localparam int PROD_W  = 64;
	localparam int CNT_W   = 7;
	localparam int MUL_STEPS = OP_W;
	localparam int DIV_STEPS = PROD_W;

	localparam logic signed [OP_W-1:0] ONE_OP = OP_W'(1) << FRAC_BITS;
	localparam logic signed [OP_W-1:0] TWO_OP = OP_W'(2) << FRAC_BITS;

	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// Opcodes
	localparam logic [1:0] OP_LOAD_SPOT = 2'd0;
	localparam logic [1:0] OP_LOAD_VAR  = 2'd1;
	localparam logic [1:0] OP_LOAD_NODE = 2'd2;
	localparam logic [1:0] OP_QUERY     = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_BAD = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_POINTS_SPOT = 2'd0;
	localparam logic [1:0] CFG_POINTS_VAR  = 2'd1;
	localparam logic [1:0] CFG_TIME_STEP   = 2'd2;

	// Price read slots: center, spot neighbors, variance neighbors, corners
	localparam int NUM_READS = 9;
	localparam int RD_W      = 4;
	localparam logic [RD_W-1:0] RD_CENTER  = 4'd0;
	localparam logic [RD_W-1:0] RD_SPOT_LO = 4'd1;
	localparam logic [RD_W-1:0] RD_SPOT_HI = 4'd2;
	localparam logic [RD_W-1:0] RD_VAR_LO  = 4'd3;
	localparam logic [RD_W-1:0] RD_VAR_HI  = 4'd4;
	localparam logic [RD_W-1:0] RD_HI_HI   = 4'd5;
	localparam logic [RD_W-1:0] RD_LO_HI   = 4'd6;
	localparam logic [RD_W-1:0] RD_HI_LO   = 4'd7;
	localparam logic [RD_W-1:0] RD_LO_LO   = 4'd8;
	localparam logic [RD_W-1:0] RD_END     = 4'd9;

	// Division steps of one query
	localparam int NUM_STEPS = 11;
	localparam int STEP_W    = 4;
	localparam logic [STEP_W-1:0] STEP_DM_S    = 4'd0;
	localparam logic [STEP_W-1:0] STEP_DP_S    = 4'd1;
	localparam logic [STEP_W-1:0] STEP_CORR_S  = 4'd2;
	localparam logic [STEP_W-1:0] STEP_SEC_S   = 4'd3;
	localparam logic [STEP_W-1:0] STEP_DM_V    = 4'd4;
	localparam logic [STEP_W-1:0] STEP_DP_V    = 4'd5;
	localparam logic [STEP_W-1:0] STEP_CORR_V  = 4'd6;
	localparam logic [STEP_W-1:0] STEP_SEC_V   = 4'd7;
	localparam logic [STEP_W-1:0] STEP_THETA   = 4'd8;
	localparam logic [STEP_W-1:0] STEP_CROSS   = 4'd9;
	localparam logic [STEP_W-1:0] STEP_VANNA   = 4'd10;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_READ,
		CS_CHECK,
		CS_CALC,
		CS_WAIT,
		CS_FIN
	} ctl_state_t;

	typedef enum logic [1:0] {
		DS_IDLE,
		DS_MUL,
		DS_DIV,
		DS_DONE
	} div_state_t;

	typedef struct packed {
		logic                   start;
		logic signed [OP_W-1:0] a;
		logic signed [OP_W-1:0] b;
		logic signed [OP_W-1:0] c;
	} div_req_t;

	typedef struct packed {
		logic                     busy;
		logic                     done;
		logic                     sat;
		logic signed [DATA_W-1:0] q;
	} div_rsp_t;

	function automatic logic [OP_W-1:0] mag(input logic signed [OP_W-1:0] x);
		logic [OP_W-1:0] r;
		r = x[OP_W-1] ? OP_W'(-x) : OP_W'(x);
		return r;
	endfunction

endpackage

>>> design/ngg_ram.sv
// Generic single-port RAM with registered read data.
// Standalone; no package needed.
module ngg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, then register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> design/ngg_div.sv
// Shared iterative unit: q = trunc(a*b/c), saturated to 32 bits.
// Shift-add multiply one bit a cycle, then restoring division; uses ngg_pkg.
module ngg_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ngg_pkg::div_req_t req,
	output ngg_pkg::div_rsp_t rsp
);

	ngg_pkg::div_state_t state_q, state_d;
	logic [ngg_pkg::CNT_W-1:0]  cnt_q;
	logic [ngg_pkg::PROD_W-1:0] ma_q;
	logic [ngg_pkg::PROD_W-1:0] acc_q;
	logic [ngg_pkg::OP_W-1:0]   mb_q;
	logic [ngg_pkg::OP_W-1:0]   mc_q;
	logic [ngg_pkg::OP_W-1:0]   rem_q;
	logic                       neg_q;
	logic [ngg_pkg::OP_W:0]     trial;
	logic                       ge;
	logic                       mul_last, div_last;
	logic                       ovf;

	assign mul_last = (state_q == ngg_pkg::DS_MUL)
		&& (cnt_q == ngg_pkg::CNT_W'(ngg_pkg::MUL_STEPS - 1));
	assign div_last = (state_q == ngg_pkg::DS_DIV)
		&& (cnt_q == ngg_pkg::CNT_W'(ngg_pkg::DIV_STEPS - 1));
	assign trial    = {rem_q, acc_q[ngg_pkg::PROD_W-1]};
	assign ge       = (trial >= {1'b0, mc_q});

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ngg_pkg::DS_IDLE: if (req.start) state_d = ngg_pkg::DS_MUL;
			ngg_pkg::DS_MUL:  if (mul_last) state_d = ngg_pkg::DS_DIV;
			ngg_pkg::DS_DIV:  if (div_last) state_d = ngg_pkg::DS_DONE;
			ngg_pkg::DS_DONE: state_d = ngg_pkg::DS_IDLE;
			default:          state_d = ngg_pkg::DS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ngg_pkg::DS_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ngg_pkg::DS_IDLE || mul_last || div_last) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Datapath: load magnitudes, accumulate product, shift out quotient
	always_ff @(posedge clk) begin
		unique case (state_q)
			ngg_pkg::DS_IDLE: begin
				if (req.start) begin
					ma_q  <= ngg_pkg::PROD_W'(ngg_pkg::mag(req.a));
					mb_q  <= ngg_pkg::mag(req.b);
					mc_q  <= ngg_pkg::mag(req.c);
					neg_q <= req.a[ngg_pkg::OP_W-1] ^ req.b[ngg_pkg::OP_W-1]
						^ req.c[ngg_pkg::OP_W-1];
					acc_q <= '0;
					rem_q <= '0;
				end
			end
			ngg_pkg::DS_MUL: begin
				if (mb_q[0]) begin
					acc_q <= acc_q + ma_q;
				end
				ma_q <= {ma_q[ngg_pkg::PROD_W-2:0], 1'b0};
				mb_q <= {1'b0, mb_q[ngg_pkg::OP_W-1:1]};
			end
			ngg_pkg::DS_DIV: begin
				rem_q <= ge ? ngg_pkg::OP_W'(trial - {1'b0, mc_q})
					: trial[ngg_pkg::OP_W-1:0];
				acc_q <= {acc_q[ngg_pkg::PROD_W-2:0], ge};
			end
			default: begin
			end
		endcase
	end

	// Saturate the quotient
	always_comb begin
		if (neg_q) begin
			ovf   = (acc_q > ngg_pkg::PROD_W'(64'h8000_0000));
			rsp.q = ovf ? ngg_pkg::SAT_MIN : -$signed(acc_q[ngg_pkg::DATA_W-1:0]);
		end else begin
			ovf   = (acc_q > ngg_pkg::PROD_W'(64'h7FFF_FFFF));
			rsp.q = ovf ? ngg_pkg::SAT_MAX : $signed(acc_q[ngg_pkg::DATA_W-1:0]);
		end
		rsp.done = (state_q == ngg_pkg::DS_DONE);
		rsp.sat  = (state_q == ngg_pkg::DS_DONE) && ovf;
		rsp.busy = (state_q != ngg_pkg::DS_IDLE);
	end

endmodule

>>> design/nonuniform_grid_greeks_stencil.sv
// Top level: grid stores, query sequencer and output registers.
// Depends on ngg_pkg, ngg_ram and ngg_div.
//
//  channel  | signals                                         | handshake
//  ---------+-------------------------------------------------+----------------------
//  item in  | opcode spot_index variance_index value prev.    | start & !busy
//  result   | node_* delta gamma theta vega vanna volga status| done, one cycle
//  config   | cfg_index cfg_data                              | cfg_valid & cfg_ready
//
// Loads leave busy low. A query does the store reads, one check state, then
// up to 11 divisions on the one shared divider (36 multiply steps and 64
// divide steps each); fewer divisions run at grid edges. A query rejected for
// its configuration or indexes goes straight to the finish state.
// Reset clears control and loads the configuration defaults; stores are not
// cleared. The receiver cannot stall: done is high for exactly one cycle.
module nonuniform_grid_greeks_stencil (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          opcode,
	input  logic [ngg_pkg::SPOT_W-1:0]          spot_index,
	input  logic [ngg_pkg::VAR_W-1:0]           variance_index,
	input  logic signed [ngg_pkg::DATA_W-1:0]   value,
	input  logic signed [ngg_pkg::DATA_W-1:0]   previous_value,
	output logic                                done,
	output logic [ngg_pkg::SPOT_W-1:0]          node_spot,
	output logic [ngg_pkg::VAR_W-1:0]           node_variance,
	output logic signed [ngg_pkg::DATA_W-1:0]   delta,
	output logic signed [ngg_pkg::DATA_W-1:0]   gamma,
	output logic signed [ngg_pkg::DATA_W-1:0]   theta,
	output logic signed [ngg_pkg::DATA_W-1:0]   vega,
	output logic signed [ngg_pkg::DATA_W-1:0]   vanna,
	output logic signed [ngg_pkg::DATA_W-1:0]   volga,
	output logic [1:0]                          status,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [ngg_pkg::DATA_W-1:0]          cfg_data
);

	ngg_pkg::ctl_state_t state_q, state_d;

	logic [ngg_pkg::PTS_W-1:0]  points_spot_q, points_variance_q;
	logic [ngg_pkg::TS_W-1:0]   time_step_q;
	logic [ngg_pkg::RD_W-1:0]   rd_k_q, cap_k;
	logic [ngg_pkg::STEP_W-1:0] step_q;
	logic [ngg_pkg::SPOT_W-1:0] si_q, sm, sp, rd_s;
	logic [ngg_pkg::VAR_W-1:0]  vi_q, vm, vp, rd_v;
	logic                       bad_q, sat_q, done_q;
	logic                       accept, cfg_bad, spacing_bad;
	logic                       s_first, s_last, s_int, v_first, v_last, v_int;

	logic signed [ngg_pkg::DATA_W-1:0] sx_q [3];
	logic signed [ngg_pkg::DATA_W-1:0] vx_q [3];
	logic signed [ngg_pkg::DATA_W-1:0] p_q [ngg_pkg::NUM_READS];
	logic signed [ngg_pkg::DATA_W-1:0] pv_q;
	logic signed [ngg_pkg::DATA_W-1:0] res_q [ngg_pkg::NUM_STEPS];

	logic [ngg_pkg::DATA_W-1:0] spot_rdata, var_rdata, price_rdata, prev_rdata;
	logic [ngg_pkg::SPOT_W-1:0] spot_addr;
	logic [ngg_pkg::VAR_W-1:0]  var_addr;
	logic [ngg_pkg::NODE_W-1:0] node_addr;

	logic signed [ngg_pkg::DATA_W:0]   hms, hps, hmv, hpv;
	logic signed [ngg_pkg::DATA_W+1:0] dss, dsv;
	logic signed [ngg_pkg::DATA_W:0]   sum_s, sum_v;
	logic signed [ngg_pkg::DATA_W-1:0] delta_d, vega_d;
	logic                              ovf_s, ovf_v, need;

	ngg_pkg::div_req_t div_req;
	ngg_pkg::div_rsp_t div_rsp;

	assign accept    = start && !busy;
	assign busy      = (state_q != ngg_pkg::CS_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_spot_q     <= ngg_pkg::PTS_W'(64);
			points_variance_q <= ngg_pkg::PTS_W'(64);
			time_step_q       <= ngg_pkg::TS_W'(65536);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ngg_pkg::CFG_POINTS_SPOT: points_spot_q <= cfg_data[ngg_pkg::PTS_W-1:0];
				ngg_pkg::CFG_POINTS_VAR:  points_variance_q <= cfg_data[ngg_pkg::PTS_W-1:0];
				ngg_pkg::CFG_TIME_STEP:   time_step_q <= cfg_data[ngg_pkg::TS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Node position and clipped neighbors
	assign s_first = (si_q == '0);
	assign s_last  = ({1'b0, si_q} == points_spot_q - 1'b1);
	assign s_int   = !s_first && !s_last;
	assign v_first = (vi_q == '0);
	assign v_last  = ({1'b0, vi_q} == points_variance_q - 1'b1);
	assign v_int   = !v_first && !v_last;
	assign sm = s_first ? si_q : si_q - 1'b1;
	assign sp = s_last ? si_q : si_q + 1'b1;
	assign vm = v_first ? vi_q : vi_q - 1'b1;
	assign vp = v_last ? vi_q : vi_q + 1'b1;

	assign cfg_bad = (points_spot_q < ngg_pkg::PTS_W'(2))
		|| (points_spot_q > ngg_pkg::PTS_W'(ngg_pkg::MAX_SPOT))
		|| (points_variance_q < ngg_pkg::PTS_W'(2))
		|| (points_variance_q > ngg_pkg::PTS_W'(ngg_pkg::MAX_VARIANCE))
		|| ({1'b0, spot_index} >= points_spot_q)
		|| ({1'b0, variance_index} >= points_variance_q)
		|| (time_step_q == '0);

	// Read address sequence
	always_comb begin
		unique case (rd_k_q)
			ngg_pkg::RD_CENTER:  begin rd_s = si_q; rd_v = vi_q; end
			ngg_pkg::RD_SPOT_LO: begin rd_s = sm;   rd_v = vi_q; end
			ngg_pkg::RD_SPOT_HI: begin rd_s = sp;   rd_v = vi_q; end
			ngg_pkg::RD_VAR_LO:  begin rd_s = si_q; rd_v = vm;   end
			ngg_pkg::RD_VAR_HI:  begin rd_s = si_q; rd_v = vp;   end
			ngg_pkg::RD_HI_HI:   begin rd_s = sp;   rd_v = vp;   end
			ngg_pkg::RD_LO_HI:   begin rd_s = sm;   rd_v = vp;   end
			ngg_pkg::RD_HI_LO:   begin rd_s = sp;   rd_v = vm;   end
			ngg_pkg::RD_LO_LO:   begin rd_s = sm;   rd_v = vm;   end
			default:             begin rd_s = si_q; rd_v = vi_q; end
		endcase
	end

	// Coordinate reads: low neighbor, center, high neighbor in slots 0..2
	always_comb begin
		unique case (rd_k_q)
			ngg_pkg::RD_CENTER:  begin spot_addr = sm; var_addr = vm; end
			ngg_pkg::RD_SPOT_LO: begin spot_addr = si_q; var_addr = vi_q; end
			ngg_pkg::RD_SPOT_HI: begin spot_addr = sp; var_addr = vp; end
			default:             begin spot_addr = si_q; var_addr = vi_q; end
		endcase
		if (accept) begin
			spot_addr = spot_index;
			var_addr  = variance_index;
			node_addr = {variance_index, spot_index};
		end else begin
			node_addr = {rd_v, rd_s};
		end
	end

	ngg_ram #(.WIDTH(ngg_pkg::DATA_W), .DEPTH(ngg_pkg::MAX_SPOT)) u_spot_ram (
		.clk   (clk),
		.we    (accept && opcode == ngg_pkg::OP_LOAD_SPOT),
		.addr  (spot_addr),
		.wdata (value),
		.rdata (spot_rdata)
	);

	ngg_ram #(.WIDTH(ngg_pkg::DATA_W), .DEPTH(ngg_pkg::MAX_VARIANCE)) u_var_ram (
		.clk   (clk),
		.we    (accept && opcode == ngg_pkg::OP_LOAD_VAR),
		.addr  (var_addr),
		.wdata (value),
		.rdata (var_rdata)
	);

	ngg_ram #(.WIDTH(ngg_pkg::DATA_W),
		.DEPTH(ngg_pkg::MAX_SPOT * ngg_pkg::MAX_VARIANCE)) u_price_ram (
		.clk   (clk),
		.we    (accept && opcode == ngg_pkg::OP_LOAD_NODE),
		.addr  (node_addr),
		.wdata (value),
		.rdata (price_rdata)
	);

	ngg_ram #(.WIDTH(ngg_pkg::DATA_W),
		.DEPTH(ngg_pkg::MAX_SPOT * ngg_pkg::MAX_VARIANCE)) u_prev_ram (
		.clk   (clk),
		.we    (accept && opcode == ngg_pkg::OP_LOAD_NODE),
		.addr  (node_addr),
		.wdata (previous_value),
		.rdata (prev_rdata)
	);

	// Spacings and zero-spacing check
	assign hms = ngg_pkg::DATA_W'(0) + (33'(sx_q[1]) - 33'(sx_q[0]));
	assign hps = 33'(sx_q[2]) - 33'(sx_q[1]);
	assign hmv = 33'(vx_q[1]) - 33'(vx_q[0]);
	assign hpv = 33'(vx_q[2]) - 33'(vx_q[1]);
	assign dss = 34'(hms) + 34'(hps);
	assign dsv = 34'(hmv) + 34'(hpv);

	always_comb begin
		logic zs, zv;
		if (s_first)     zs = (hps == '0);
		else if (s_last) zs = (hms == '0);
		else             zs = (hms == '0) || (hps == '0) || (dss == '0);
		if (v_first)     zv = (hpv == '0);
		else if (v_last) zv = (hmv == '0);
		else             zv = (hmv == '0) || (hpv == '0) || (dsv == '0);
		spacing_bad = zs || zv;
	end

	// Operands of each division step
	always_comb begin
		div_req.a = '0;
		div_req.b = ngg_pkg::ONE_OP;
		div_req.c = ngg_pkg::ONE_OP;
		need      = 1'b0;
		unique case (step_q)
			ngg_pkg::STEP_DM_S: begin
				need = !s_first;
				div_req.a = 36'(p_q[ngg_pkg::RD_CENTER]) - 36'(p_q[ngg_pkg::RD_SPOT_LO]);
				div_req.c = 36'(hms);
			end
			ngg_pkg::STEP_DP_S: begin
				need = !s_last;
				div_req.a = 36'(p_q[ngg_pkg::RD_SPOT_HI]) - 36'(p_q[ngg_pkg::RD_CENTER]);
				div_req.c = 36'(hps);
			end
			ngg_pkg::STEP_CORR_S: begin
				need = s_int;
				div_req.a = 36'(hms);
				div_req.b = 36'(res_q[ngg_pkg::STEP_DP_S]) - 36'(res_q[ngg_pkg::STEP_DM_S]);
				div_req.c = 36'(dss);
			end
			ngg_pkg::STEP_SEC_S: begin
				need = s_int;
				div_req.a = 36'(res_q[ngg_pkg::STEP_DP_S]) - 36'(res_q[ngg_pkg::STEP_DM_S]);
				div_req.b = ngg_pkg::TWO_OP;
				div_req.c = 36'(dss);
			end
			ngg_pkg::STEP_DM_V: begin
				need = !v_first;
				div_req.a = 36'(p_q[ngg_pkg::RD_CENTER]) - 36'(p_q[ngg_pkg::RD_VAR_LO]);
				div_req.c = 36'(hmv);
			end
			ngg_pkg::STEP_DP_V: begin
				need = !v_last;
				div_req.a = 36'(p_q[ngg_pkg::RD_VAR_HI]) - 36'(p_q[ngg_pkg::RD_CENTER]);
				div_req.c = 36'(hpv);
			end
			ngg_pkg::STEP_CORR_V: begin
				need = v_int;
				div_req.a = 36'(hmv);
				div_req.b = 36'(res_q[ngg_pkg::STEP_DP_V]) - 36'(res_q[ngg_pkg::STEP_DM_V]);
				div_req.c = 36'(dsv);
			end
			ngg_pkg::STEP_SEC_V: begin
				need = v_int;
				div_req.a = 36'(res_q[ngg_pkg::STEP_DP_V]) - 36'(res_q[ngg_pkg::STEP_DM_V]);
				div_req.b = ngg_pkg::TWO_OP;
				div_req.c = 36'(dsv);
			end
			ngg_pkg::STEP_THETA: begin
				need = 1'b1;
				div_req.a = 36'(pv_q) - 36'(p_q[ngg_pkg::RD_CENTER]);
				div_req.c = {5'b0, time_step_q};
			end
			ngg_pkg::STEP_CROSS: begin
				need = s_int && v_int;
				div_req.a = 36'(p_q[ngg_pkg::RD_HI_HI]) - 36'(p_q[ngg_pkg::RD_LO_HI])
					- 36'(p_q[ngg_pkg::RD_HI_LO]) + 36'(p_q[ngg_pkg::RD_LO_LO]);
				div_req.c = 36'(dss);
			end
			ngg_pkg::STEP_VANNA: begin
				need = s_int && v_int;
				div_req.a = 36'(res_q[ngg_pkg::STEP_CROSS]);
				div_req.c = 36'(dsv);
			end
			default: begin
			end
		endcase
		div_req.start = (state_q == ngg_pkg::CS_CALC) && need;
	end

	ngg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ngg_pkg::CS_IDLE: begin
				if (accept && opcode == ngg_pkg::OP_QUERY) begin
					state_d = cfg_bad ? ngg_pkg::CS_FIN : ngg_pkg::CS_READ;
				end
			end
			ngg_pkg::CS_READ:  if (rd_k_q == ngg_pkg::RD_END) state_d = ngg_pkg::CS_CHECK;
			ngg_pkg::CS_CHECK: state_d = spacing_bad ? ngg_pkg::CS_FIN : ngg_pkg::CS_CALC;
			ngg_pkg::CS_CALC: begin
				if (need) state_d = ngg_pkg::CS_WAIT;
				else if (step_q == ngg_pkg::STEP_VANNA) state_d = ngg_pkg::CS_FIN;
			end
			ngg_pkg::CS_WAIT: begin
				if (div_rsp.done) begin
					state_d = (step_q == ngg_pkg::STEP_VANNA) ? ngg_pkg::CS_FIN
						: ngg_pkg::CS_CALC;
				end
			end
			ngg_pkg::CS_FIN:   state_d = ngg_pkg::CS_IDLE;
			default:           state_d = ngg_pkg::CS_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ngg_pkg::CS_IDLE;
			rd_k_q  <= '0;
			step_q  <= '0;
			bad_q   <= 1'b0;
			sat_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ngg_pkg::CS_FIN);
			if (state_q == ngg_pkg::CS_IDLE) begin
				rd_k_q <= '0;
				step_q <= '0;
				sat_q  <= 1'b0;
				bad_q  <= cfg_bad;
			end
			if (state_q == ngg_pkg::CS_READ) begin
				rd_k_q <= rd_k_q + 1'b1;
			end
			if (state_q == ngg_pkg::CS_CHECK) begin
				bad_q <= spacing_bad;
			end
			// advance past skipped steps and finished divisions
			if ((state_q == ngg_pkg::CS_CALC && !need)
				|| (state_q == ngg_pkg::CS_WAIT && div_rsp.done)) begin
				step_q <= step_q + 1'b1;
			end
			if (state_q == ngg_pkg::CS_WAIT && div_rsp.done) begin
				sat_q <= sat_q | div_rsp.sat;
			end
		end
	end

	// Capture read data in the cycle after its address
	assign cap_k = rd_k_q - 1'b1;

	always_ff @(posedge clk) begin
		if (accept) begin
			si_q <= spot_index;
			vi_q <= variance_index;
		end
		if (state_q == ngg_pkg::CS_READ && rd_k_q != ngg_pkg::RD_CENTER) begin
			p_q[cap_k] <= price_rdata;
			if (cap_k < ngg_pkg::RD_W'(3)) begin
				sx_q[cap_k[1:0]] <= spot_rdata;
				vx_q[cap_k[1:0]] <= var_rdata;
			end
			if (cap_k == ngg_pkg::RD_CENTER) begin
				pv_q <= prev_rdata;
			end
		end
		if (state_q == ngg_pkg::CS_WAIT && div_rsp.done) begin
			res_q[step_q] <= div_rsp.q;
		end
	end

	// Interior first derivatives: slope plus correction, saturated
	assign sum_s = 33'(res_q[ngg_pkg::STEP_DM_S]) + 33'(res_q[ngg_pkg::STEP_CORR_S]);
	assign sum_v = 33'(res_q[ngg_pkg::STEP_DM_V]) + 33'(res_q[ngg_pkg::STEP_CORR_V]);
	assign ovf_s = sum_s[ngg_pkg::DATA_W] != sum_s[ngg_pkg::DATA_W-1];
	assign ovf_v = sum_v[ngg_pkg::DATA_W] != sum_v[ngg_pkg::DATA_W-1];

	always_comb begin
		if (s_int) begin
			delta_d = ovf_s ? (sum_s[ngg_pkg::DATA_W] ? ngg_pkg::SAT_MIN : ngg_pkg::SAT_MAX)
				: sum_s[ngg_pkg::DATA_W-1:0];
		end else begin
			delta_d = s_first ? res_q[ngg_pkg::STEP_DP_S] : res_q[ngg_pkg::STEP_DM_S];
		end
		if (v_int) begin
			vega_d = ovf_v ? (sum_v[ngg_pkg::DATA_W] ? ngg_pkg::SAT_MIN : ngg_pkg::SAT_MAX)
				: sum_v[ngg_pkg::DATA_W-1:0];
		end else begin
			vega_d = v_first ? res_q[ngg_pkg::STEP_DP_V] : res_q[ngg_pkg::STEP_DM_V];
		end
	end

	// Output registers, loaded when the query finishes
	always_ff @(posedge clk) begin
		if (state_q == ngg_pkg::CS_FIN) begin
			node_spot     <= si_q;
			node_variance <= vi_q;
			if (bad_q) begin
				status <= ngg_pkg::ST_BAD;
				delta  <= '0;
				gamma  <= '0;
				theta  <= '0;
				vega   <= '0;
				vanna  <= '0;
				volga  <= '0;
			end else begin
				status <= (sat_q || (s_int && ovf_s) || (v_int && ovf_v))
					? ngg_pkg::ST_SAT : ngg_pkg::ST_OK;
				delta  <= delta_d;
				gamma  <= s_int ? res_q[ngg_pkg::STEP_SEC_S] : '0;
				theta  <= res_q[ngg_pkg::STEP_THETA];
				vega   <= vega_d;
				vanna  <= (s_int && v_int) ? res_q[ngg_pkg::STEP_VANNA] : '0;
				volga  <= v_int ? res_q[ngg_pkg::STEP_SEC_V] : '0;
			end
		end
	end

	// Checks
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ngg_pkg::ST_BAD) |-> (delta == '0 && gamma == '0
			&& theta == '0 && vega == '0 && vanna == '0 && volga == '0))
		else $error("rejected query returned nonzero values");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !div_rsp.busy)
		else $error("divider active while sequencer idle");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == ngg_pkg::OP_QUERY) |=> busy)
		else $error("query accepted without going busy");

endmodule
